### rtl/kvps_pkg.sv
// Shared constants and types for the key/value pair sorter.
package kvps_pkg;

	localparam int MaxLen  = 64;
	localparam int KeyBits = 31;
	localparam int ValBits = 64;

	typedef logic [KeyBits-1:0] key_t;
	typedef logic [ValBits-1:0] val_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;   // insert the incoming pair
		logic shl;   // shift one place toward cell zero
	} cell_ctl_t;

endpackage

### rtl/key_value_pair_sorter.sv
// Top level of the key/value pair sorter: insertion chain plus row control.
//
// Pairs of one row enter at one per cycle and are kept sorted ascending by key
// in a chain of MaxLen cells; a new pair goes behind every held pair with an
// equal or smaller key, so equal keys leave in arrival order. The beat marked
// last_in (inserted, or dropped if the chain is full) starts the drain: the
// held pairs leave from cell zero at one per cycle unless out_stall is high,
// the final one with last_out, all with overflow set if the row lost pairs.
// During the drain the input is stalled, so a row is first loaded through the
// single insert port and then drained through the single output port before
// the next row can enter.
module key_value_pair_sorter
	import kvps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [KeyBits-1:0] key,
	input  logic [ValBits-1:0] payload,
	input  logic             last_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [KeyBits-1:0] sorted_key,
	output logic [ValBits-1:0] sorted_payload,
	output logic             last_out,
	output logic             overflow
);

	logic drain_q;
	logic dropped_q;
	logic in_beat;
	logic out_beat;
	logic full;
	cell_ctl_t ctl;

	logic c_valid [MaxLen+1];
	logic c_gt    [MaxLen+1];
	key_t c_key   [MaxLen+1];
	val_t c_pay   [MaxLen+1];

	assign in_stall = drain_q;
	assign in_beat  = in_valid && !drain_q;
	assign out_beat = out_valid && !out_stall;
	assign full     = c_valid[MaxLen];

	assign ctl.ins = in_beat && !full;
	assign ctl.shl = out_beat;

	// Row control: enter drain on the last beat, leave it after the final output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (in_beat && full) begin
				dropped_q <= 1'b1;
			end
			if (in_beat && last_in) begin
				drain_q <= 1'b1;
			end
			if (out_beat && last_out) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
		end
	end

	// Boundaries of the chain: an always-present head and an empty tail
	logic tail_valid;
	key_t tail_key;
	val_t tail_pay;
	assign tail_valid = 1'b0;
	assign tail_key   = '0;
	assign tail_pay   = '0;

	// Chain of cells; cell i sits at slot i+1 and talks to slots i and i+2
	for (genvar i = 0; i < MaxLen; i++) begin : g_cell
		logic prev_valid;
		logic prev_gt;
		key_t prev_key;
		val_t prev_pay;
		logic next_valid;
		key_t next_key;
		val_t next_pay;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign prev_gt    = 1'b0;
			assign prev_key   = key;
			assign prev_pay   = payload;
		end else begin : g_body
			assign prev_valid = c_valid[i];
			assign prev_gt    = c_gt[i];
			assign prev_key   = c_key[i];
			assign prev_pay   = c_pay[i];
		end

		if (i == MaxLen - 1) begin : g_tail
			assign next_valid = tail_valid;
			assign next_key   = tail_key;
			assign next_pay   = tail_pay;
		end else begin : g_mid
			assign next_valid = c_valid[i+2];
			assign next_key   = c_key[i+2];
			assign next_pay   = c_pay[i+2];
		end

		kvps_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.new_key      (key),
			.new_payload  (payload),
			.prev_valid   (prev_valid),
			.prev_gt      (prev_gt),
			.prev_key     (prev_key),
			.prev_payload (prev_pay),
			.next_valid   (next_valid),
			.next_key     (next_key),
			.next_payload (next_pay),
			.valid        (c_valid[i+1]),
			.gt           (c_gt[i+1]),
			.key          (c_key[i+1]),
			.payload      (c_pay[i+1])
		);
	end

	// Slot zero of the arrays is unused; tie it off
	assign c_valid[0] = 1'b0;
	assign c_gt[0]    = 1'b0;
	assign c_key[0]   = '0;
	assign c_pay[0]   = '0;

	// Output beat comes straight from the head cell
	assign out_valid      = drain_q;
	assign sorted_key     = c_key[1];
	assign sorted_payload = c_pay[1];
	assign last_out       = !c_valid[2];
	assign overflow       = dropped_q;

endmodule

### rtl/kvps_cell.sv
// One cell of the insertion chain: holds a single key/payload pair.
module kvps_cell
	import kvps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  key_t      new_key,
	input  val_t      new_payload,
	input  logic      prev_valid,
	input  logic      prev_gt,
	input  key_t      prev_key,
	input  val_t      prev_payload,
	input  logic      next_valid,
	input  key_t      next_key,
	input  val_t      next_payload,
	output logic      valid,
	output logic      gt,
	output key_t      key,
	output val_t      payload
);

	logic valid_q;
	key_t key_q;
	val_t payload_q;

	// Stored key lies strictly above the incoming key
	assign gt = valid_q && (key_q > new_key);

	// Track occupancy: grow from the front on insert, shrink from the back on drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shl) begin
			valid_q <= next_valid;
		end else if (ctl.ins) begin
			valid_q <= valid_q | prev_valid;
		end
	end

	// Shift up behind a larger key, take the new pair at its slot, or advance on drain
	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			key_q     <= next_key;
			payload_q <= next_payload;
		end else if (ctl.ins) begin
			if (prev_gt) begin
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end else if (gt || !valid_q) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end
	end

	assign valid   = valid_q;
	assign key     = key_q;
	assign payload = payload_q;

endmodule
